// ===== hdl/polygon_area_elastic_energy_macros.svh =====
// Assertion macros shared by the polygon area elastic energy RTL
`ifndef POLYGON_AREA_ELASTIC_ENERGY_MACROS_SVH
`define POLYGON_AREA_ELASTIC_ENERGY_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define PAE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PAE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/pae_pkg.sv =====
// Package: constants, sequencer states and control types for the polygon area block
package pae_pkg;

	// Fraction bits of the vertex coordinates
	localparam int COORD_FRAC_BITS = 16;

	// Cross sum carries 2*COORD_FRAC_BITS fraction bits; area is Q32.32 after halving
	localparam int AREA_SHIFT = 31 - 2 * COORD_FRAC_BITS;
	localparam int AREA_LSH   = (AREA_SHIFT > 0) ? AREA_SHIFT : 0;
	localparam int AREA_RSH   = (AREA_SHIFT < 0) ? -AREA_SHIFT : 0;

	// Energy: d^2 (64 fraction bits) times k (16 fraction bits), halved, to Q32.32
	localparam int ENERGY_SHIFT = 49;

	localparam logic [31:0] STIFF_RESET = 32'd65536;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CR_A,
		ST_CR_B,
		ST_CR_C,
		ST_CR_SUM,
		ST_CL_A,
		ST_CL_B,
		ST_CL_C,
		ST_CL_SUM,
		ST_AREA,
		ST_MAG,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQ3,
		ST_K,
		ST_K_LAST,
		ST_OUT
	} state_t;

	// Operand pair fed to the shared multiplier
	typedef enum logic [2:0] {
		MS_PREVX_Y,
		MS_X_PREVY,
		MS_X_FIRSTY,
		MS_FIRSTX_Y,
		MS_LO_LO,
		MS_LO_HI,
		MS_HI_HI,
		MS_W_K
	} mul_sel_t;

	// Datapath register update for the cycle
	typedef enum logic [3:0] {
		DP_NONE,
		DP_ACCEPT,
		DP_DIFF_LOAD,
		DP_DIFF_SUB,
		DP_CROSS_SUM,
		DP_AREA,
		DP_MAG,
		DP_W_LOAD,
		DP_W_ADD33,
		DP_W_ADD64,
		DP_K_STEP,
		DP_K_LAST,
		DP_OUT
	} dp_op_t;

	// Sequencer to datapath
	typedef struct packed {
		logic     idle;
		mul_sel_t msel;
		dp_op_t   op;
		logic     k_consume;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic mid;
		logic last;
		logic out_free;
	} stat_t;

endpackage

// ===== hdl/pae_mul.sv =====
// Shared 33x33 signed multiplier with registered product
module pae_mul (
	input  logic               clk,
	input  logic signed [32:0] op_a,
	input  logic signed [32:0] op_b,
	output logic signed [65:0] prod
);

	logic signed [65:0] prod_q;

	// One product per cycle, available the cycle after issue
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// ===== hdl/pae_ctrl.sv =====
// Sequencer that steps the shared multiplier through cross, area and energy terms
`include "polygon_area_elastic_energy_macros.svh"

module pae_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           last_vertex,
	input  pae_pkg::stat_t stat,
	output pae_pkg::ctrl_t ctrl
);

	pae_pkg::state_t state_q, state_d;
	logic [1:0]      kcnt_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pae_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Limb counter for the stiffness pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= 2'd0;
		end else if (state_q == pae_pkg::ST_K) begin
			kcnt_q <= kcnt_q + 2'd1;
		end else begin
			kcnt_q <= 2'd0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pae_pkg::ST_IDLE: begin
				if (accept) begin
					if (stat.mid) begin
						state_d = pae_pkg::ST_CR_A;
					end else if (last_vertex) begin
						state_d = pae_pkg::ST_CL_A;
					end
				end
			end
			pae_pkg::ST_CR_A:   state_d = pae_pkg::ST_CR_B;
			pae_pkg::ST_CR_B:   state_d = pae_pkg::ST_CR_C;
			pae_pkg::ST_CR_C:   state_d = pae_pkg::ST_CR_SUM;
			pae_pkg::ST_CR_SUM: state_d = stat.last ? pae_pkg::ST_CL_A : pae_pkg::ST_IDLE;
			pae_pkg::ST_CL_A:   state_d = pae_pkg::ST_CL_B;
			pae_pkg::ST_CL_B:   state_d = pae_pkg::ST_CL_C;
			pae_pkg::ST_CL_C:   state_d = pae_pkg::ST_CL_SUM;
			pae_pkg::ST_CL_SUM: state_d = pae_pkg::ST_AREA;
			pae_pkg::ST_AREA:   state_d = pae_pkg::ST_MAG;
			pae_pkg::ST_MAG:    state_d = pae_pkg::ST_SQ0;
			pae_pkg::ST_SQ0:    state_d = pae_pkg::ST_SQ1;
			pae_pkg::ST_SQ1:    state_d = pae_pkg::ST_SQ2;
			pae_pkg::ST_SQ2:    state_d = pae_pkg::ST_SQ3;
			pae_pkg::ST_SQ3:    state_d = pae_pkg::ST_K;
			pae_pkg::ST_K:      state_d = (kcnt_q == 2'd3) ? pae_pkg::ST_K_LAST : pae_pkg::ST_K;
			pae_pkg::ST_K_LAST: state_d = pae_pkg::ST_OUT;
			pae_pkg::ST_OUT:    state_d = stat.out_free ? pae_pkg::ST_IDLE : pae_pkg::ST_OUT;
			default:            state_d = pae_pkg::ST_IDLE;
		endcase
	end

	// Outputs: operand select issues, op consumes the previous product
	always_comb begin
		ctrl.idle      = 1'b0;
		ctrl.msel      = pae_pkg::MS_PREVX_Y;
		ctrl.op        = pae_pkg::DP_NONE;
		ctrl.k_consume = 1'b0;
		unique case (state_q)
			pae_pkg::ST_IDLE: begin
				ctrl.idle = 1'b1;
				ctrl.op   = accept ? pae_pkg::DP_ACCEPT : pae_pkg::DP_NONE;
			end
			pae_pkg::ST_CR_A: ctrl.msel = pae_pkg::MS_PREVX_Y;
			pae_pkg::ST_CR_B: begin
				ctrl.msel = pae_pkg::MS_X_PREVY;
				ctrl.op   = pae_pkg::DP_DIFF_LOAD;
			end
			pae_pkg::ST_CR_C:   ctrl.op = pae_pkg::DP_DIFF_SUB;
			pae_pkg::ST_CR_SUM: ctrl.op = pae_pkg::DP_CROSS_SUM;
			pae_pkg::ST_CL_A:   ctrl.msel = pae_pkg::MS_X_FIRSTY;
			pae_pkg::ST_CL_B: begin
				ctrl.msel = pae_pkg::MS_FIRSTX_Y;
				ctrl.op   = pae_pkg::DP_DIFF_LOAD;
			end
			pae_pkg::ST_CL_C:   ctrl.op = pae_pkg::DP_DIFF_SUB;
			pae_pkg::ST_CL_SUM: ctrl.op = pae_pkg::DP_CROSS_SUM;
			pae_pkg::ST_AREA:   ctrl.op = pae_pkg::DP_AREA;
			pae_pkg::ST_MAG:    ctrl.op = pae_pkg::DP_MAG;
			pae_pkg::ST_SQ0:    ctrl.msel = pae_pkg::MS_LO_LO;
			pae_pkg::ST_SQ1: begin
				ctrl.msel = pae_pkg::MS_LO_HI;
				ctrl.op   = pae_pkg::DP_W_LOAD;
			end
			pae_pkg::ST_SQ2: begin
				ctrl.msel = pae_pkg::MS_HI_HI;
				ctrl.op   = pae_pkg::DP_W_ADD33;
			end
			pae_pkg::ST_SQ3: ctrl.op = pae_pkg::DP_W_ADD64;
			pae_pkg::ST_K: begin
				ctrl.msel      = pae_pkg::MS_W_K;
				ctrl.op        = pae_pkg::DP_K_STEP;
				ctrl.k_consume = (kcnt_q != 2'd0);
			end
			pae_pkg::ST_K_LAST: ctrl.op = pae_pkg::DP_K_LAST;
			pae_pkg::ST_OUT:    ctrl.op = stat.out_free ? pae_pkg::DP_OUT : pae_pkg::DP_NONE;
			default:            ctrl.op = pae_pkg::DP_NONE;
		endcase
	end

	`PAE_ASSERT_SAME(a_kcnt_only_in_k, clk, arst_n, state_q != pae_pkg::ST_K, kcnt_q == 2'd0, "limb counter moved outside the stiffness pass")
	`PAE_ASSERT_SAME(a_k_last_after_four, clk, arst_n, state_q == pae_pkg::ST_K_LAST, $past(state_q) == pae_pkg::ST_K && $past(kcnt_q) == 2'd3, "stiffness pass ended early")
	`PAE_ASSERT_SAME(a_accept_when_idle, clk, arst_n, accept, state_q == pae_pkg::ST_IDLE, "vertex taken while busy")

endmodule

// ===== hdl/polygon_area_elastic_energy.sv =====
// Top level: shoelace polygon area and area-elastic energy on one shared multiplier
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------------
//  in       | in_valid, in_stall  | vertex_x, vertex_y, target_area, last_vertex
//  out      | out_valid, out_stall| polygon_index, signed_area, elastic_energy, energy_saturated
//  config   | area_stiffness_we   | area_stiffness
//
// First vertex of a polygon: only registered, unless it is also the closing vertex.
// Other vertices: two cross products on the shared 33x33 multiplier.
// Closing vertex: 4 cross (2 if it is also the first), 3 square and 4 stiffness limb products.
// The result sits in an output register; a new vertex is taken while it waits, and the
// block holds in its final state only if a second result is ready before the first leaves.
// Reset clears the polygon counter, the mid-polygon flag and out_valid, and sets stiffness to 1.0.
`include "polygon_area_elastic_energy_macros.svh"

module polygon_area_elastic_energy (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               area_stiffness_we,
	input  logic [31:0]        area_stiffness,
	// vertex requests
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vertex_x,
	input  logic signed [31:0] vertex_y,
	input  logic [62:0]        target_area,
	input  logic               last_vertex,
	// results
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        polygon_index,
	output logic signed [63:0] signed_area,
	output logic [63:0]        elastic_energy,
	output logic               energy_saturated
);

	pae_pkg::ctrl_t ctrl;
	pae_pkg::stat_t stat;

	logic               accept;
	logic [31:0]        stiff_q;
	logic               mid_q;
	logic [15:0]        counter_q;
	logic               out_valid_q;

	logic signed [31:0] x_q, y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [62:0]        target_q;
	logic               last_q;
	logic signed [63:0] cross_q;
	logic signed [64:0] diff_q;
	logic signed [63:0] area_q;
	logic [63:0]        mag_q;
	logic [127:0]       w_q;
	logic [127:0]       r_q;
	logic [31:0]        carry_q;

	logic [15:0]        index_q;
	logic signed [63:0] area_out_q;
	logic [63:0]        energy_q;
	logic               sat_q;

	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod;
	logic signed [65:0] sum66;
	logic signed [63:0] cross_sat;
	logic signed [95:0] area_ext;
	logic signed [95:0] area_sh;
	logic signed [63:0] area_sat;
	logic [63:0]        mag_d;
	logic [63:0]        k_sum;
	logic               sat_d;
	logic [63:0]        energy_d;

	assign accept   = in_valid && ctrl.idle;
	assign in_stall = !ctrl.idle;

	assign stat.mid      = mid_q;
	assign stat.last     = last_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	pae_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.last_vertex (last_vertex),
		.stat        (stat),
		.ctrl        (ctrl)
	);

	// Operand select for the shared multiplier
	always_comb begin
		unique case (ctrl.msel)
			pae_pkg::MS_PREVX_Y: begin
				op_a = {prev_x_q[31], prev_x_q};
				op_b = {y_q[31], y_q};
			end
			pae_pkg::MS_X_PREVY: begin
				op_a = {x_q[31], x_q};
				op_b = {prev_y_q[31], prev_y_q};
			end
			pae_pkg::MS_X_FIRSTY: begin
				op_a = {x_q[31], x_q};
				op_b = {first_y_q[31], first_y_q};
			end
			pae_pkg::MS_FIRSTX_Y: begin
				op_a = {first_x_q[31], first_x_q};
				op_b = {y_q[31], y_q};
			end
			pae_pkg::MS_LO_LO: begin
				op_a = {1'b0, mag_q[31:0]};
				op_b = {1'b0, mag_q[31:0]};
			end
			pae_pkg::MS_LO_HI: begin
				op_a = {1'b0, mag_q[31:0]};
				op_b = {1'b0, mag_q[63:32]};
			end
			pae_pkg::MS_HI_HI: begin
				op_a = {1'b0, mag_q[63:32]};
				op_b = {1'b0, mag_q[63:32]};
			end
			pae_pkg::MS_W_K: begin
				op_a = {1'b0, w_q[31:0]};
				op_b = {1'b0, stiff_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	pae_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// Saturating accumulate of the cross difference
	always_comb begin
		sum66 = {{2{cross_q[63]}}, cross_q} + {diff_q[64], diff_q};
		if (sum66[65:63] != {3{sum66[65]}}) begin
			cross_sat = sum66[65] ? pae_pkg::S64_MIN : pae_pkg::S64_MAX;
		end else begin
			cross_sat = sum66[63:0];
		end
	end

	// Halve to Q32.32: saturating left shift or flooring right shift
	always_comb begin
		area_ext = {{32{cross_q[63]}}, cross_q};
		area_sh  = (area_ext <<< pae_pkg::AREA_LSH) >>> pae_pkg::AREA_RSH;
		if (area_sh[95:63] != {33{area_sh[95]}}) begin
			area_sat = area_sh[95] ? pae_pkg::S64_MIN : pae_pkg::S64_MAX;
		end else begin
			area_sat = area_sh[63:0];
		end
	end

	// Distance from the rest area
	always_comb begin
		if (!area_q[63] && ($unsigned(area_q) >= {1'b0, target_q})) begin
			mag_d = $unsigned(area_q) - {1'b0, target_q};
		end else begin
			mag_d = {1'b0, target_q} - $unsigned(area_q);
		end
	end

	// Stiffness limb product plus running carry
	assign k_sum = prod[63:0] + {32'd0, carry_q};

	// Clip and rescale the energy
	assign sat_d    = (carry_q != 32'd0) || (r_q[127:113] != 15'd0);
	assign energy_d = sat_d ? {64{1'b1}} : r_q[pae_pkg::ENERGY_SHIFT +: 64];

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			pae_pkg::DP_ACCEPT: begin
				x_q      <= vertex_x;
				y_q      <= vertex_y;
				target_q <= target_area;
				last_q   <= last_vertex;
				if (!mid_q) begin
					first_x_q <= vertex_x;
					first_y_q <= vertex_y;
					prev_x_q  <= vertex_x;
					prev_y_q  <= vertex_y;
					cross_q   <= '0;
				end
			end
			pae_pkg::DP_DIFF_LOAD: diff_q <= prod[64:0];
			pae_pkg::DP_DIFF_SUB:  diff_q <= diff_q - prod[64:0];
			pae_pkg::DP_CROSS_SUM: begin
				cross_q  <= cross_sat;
				prev_x_q <= x_q;
				prev_y_q <= y_q;
			end
			pae_pkg::DP_AREA:    area_q <= area_sat;
			pae_pkg::DP_MAG:     mag_q  <= mag_d;
			pae_pkg::DP_W_LOAD:  w_q    <= {64'd0, prod[63:0]};
			pae_pkg::DP_W_ADD33: w_q    <= w_q + ({64'd0, prod[63:0]} << 33);
			pae_pkg::DP_W_ADD64: begin
				w_q     <= w_q + {prod[63:0], 64'd0};
				carry_q <= '0;
			end
			pae_pkg::DP_K_STEP: begin
				w_q <= w_q >> 32;
				if (ctrl.k_consume) begin
					r_q     <= {k_sum[31:0], r_q[127:32]};
					carry_q <= k_sum[63:32];
				end
			end
			pae_pkg::DP_K_LAST: begin
				r_q     <= {k_sum[31:0], r_q[127:32]};
				carry_q <= k_sum[63:32];
			end
			pae_pkg::DP_OUT: begin
				index_q    <= counter_q;
				area_out_q <= area_q;
				energy_q   <= energy_d;
				sat_q      <= sat_d;
				cross_q    <= '0;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q     <= pae_pkg::STIFF_RESET;
			mid_q       <= 1'b0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (area_stiffness_we) begin
				stiff_q <= area_stiffness;
			end
			if (ctrl.op == pae_pkg::DP_ACCEPT) begin
				mid_q <= 1'b1;
			end else if (ctrl.op == pae_pkg::DP_OUT) begin
				mid_q <= 1'b0;
			end
			if (ctrl.op == pae_pkg::DP_OUT) begin
				counter_q   <= counter_q + 16'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign polygon_index    = index_q;
	assign signed_area      = area_out_q;
	assign elastic_energy   = energy_q;
	assign energy_saturated = sat_q;

	`PAE_ASSERT_NEXT(a_write_closes_polygon, clk, arst_n, ctrl.op == pae_pkg::DP_OUT, out_valid_q && !mid_q && cross_q == 64'sd0, "polygon state not cleared after result write")
	`PAE_ASSERT_NEXT(a_index_counts, clk, arst_n, ctrl.op == pae_pkg::DP_OUT, polygon_index == $past(counter_q) && counter_q == $past(counter_q) + 16'd1, "polygon index out of step")
	`PAE_ASSERT_SAME(a_valid_from_write, clk, arst_n, $rose(out_valid_q), $past(ctrl.op == pae_pkg::DP_OUT), "result shown without a write")

endmodule
